@@ hdl/efld_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efld_pkg
// Shared types, codes and constants of the escaped field list decoder.
// ----------------------------------------------------------------------------
package efld_pkg;

	// marker bytes that the marker register can hold, and the longest marker
	localparam int MARKER_BYTES   = 2;
	localparam int MAX_MARKER_LEN = 2;

	// result queue depth: two results per byte at most
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_MARKER_LEN = 2'd0,
		REG_START_MARK = 2'd1,
		REG_ESCAPE     = 2'd2,
		REG_SEPARATOR  = 2'd3
	} reg_idx_t;

	// result kinds
	typedef enum logic [2:0] {
		KIND_DATA     = 3'd0,
		KIND_FIELD    = 3'd1,
		KIND_LIST     = 3'd2,
		KIND_BAD_MARK = 3'd3,
		KIND_BAD_ESC  = 3'd4
	} kind_t;

	// decoder phases
	typedef enum logic [1:0] {
		PH_MARKER = 2'd0,
		PH_BODY   = 2'd1,
		PH_ESC    = 2'd2,
		PH_DROP   = 2'd3
	} phase_t;

	typedef struct packed {
		logic [1:0]  marker_length;
		logic [15:0] start_marker;
		logic [7:0]  escape_char;
		logic [7:0]  separator_char;
	} cfg_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] out_byte;
		logic       run_last;
	} result_t;

	typedef struct packed {
		phase_t     phase;
		logic [1:0] marker_pos;
	} dec_state_t;

	// build one result; the byte only travels with data words
	function automatic result_t make_result(kind_t kind, logic [7:0] b);
		result_t r;
		r.kind     = kind;
		r.out_byte = (kind == KIND_DATA) ? b : 8'h00;
		r.run_last = 1'b0;
		return r;
	endfunction

endpackage

@@ hdl/efld_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efld_decode
// Decoder state and the per-byte logic that turns one registered input byte
// into zero, one or two results.
// ----------------------------------------------------------------------------
module efld_decode import efld_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] in_byte,
	input  logic       end_of_string,
	input  cfg_t       cfg,
	output logic [1:0] res_cnt,
	output result_t    res0,
	output result_t    res1,
	output dec_state_t st
);

	phase_t     phase_q, phase_d;
	logic [1:0] pos_q, pos_d, pos_inc;
	logic [1:0] eff_len;
	logic [7:0] want;
	phase_t     body_ph;

	// effective marker length, clamped to the longest supported marker
	assign eff_len = (cfg.marker_length > 2'(MAX_MARKER_LEN)) ?
	                 2'(MAX_MARKER_LEN) : cfg.marker_length;

	// expected marker byte; bytes past the register read as zero
	always_comb begin
		case (pos_q)
			2'd0:    want = cfg.start_marker[7:0];
			2'd1:    want = cfg.start_marker[15:8];
			default: want = 8'h00;
		endcase
	end

	assign pos_inc = pos_q + 2'd1;

	// per-byte decode
	always_comb begin
		res_cnt = 2'd0;
		res0    = make_result(KIND_DATA, 8'h00);
		res1    = make_result(KIND_DATA, 8'h00);
		phase_d = phase_q;
		pos_d   = pos_q;
		body_ph = (phase_q == PH_MARKER) ? PH_BODY : phase_q;

		if (phase_q == PH_MARKER && pos_q < eff_len) begin
			if (in_byte != want) begin
				res_cnt = 2'd1;
				res0    = make_result(KIND_BAD_MARK, 8'h00);
				phase_d = PH_DROP;
			end else begin
				pos_d = pos_inc;
				if (pos_inc >= eff_len) begin
					phase_d = PH_BODY;
					if (end_of_string) begin
						res_cnt = 2'd1;
						res0    = make_result(KIND_LIST, 8'h00);
					end
				end else if (end_of_string) begin
					res_cnt = 2'd1;
					res0    = make_result(KIND_BAD_MARK, 8'h00);
				end
			end
		end else begin
			phase_d = body_ph;
			case (body_ph)
				PH_DROP: begin
				end
				PH_ESC: begin
					if (in_byte == cfg.escape_char || in_byte == cfg.separator_char) begin
						res_cnt = end_of_string ? 2'd2 : 2'd1;
						res0    = make_result(KIND_DATA, in_byte);
						res1    = make_result(KIND_LIST, 8'h00);
						phase_d = PH_BODY;
					end else begin
						res_cnt = 2'd1;
						res0    = make_result(KIND_BAD_ESC, 8'h00);
						phase_d = PH_DROP;
					end
				end
				default: begin
					// body byte
					if (in_byte == cfg.escape_char) begin
						if (end_of_string) begin
							res_cnt = 2'd1;
							res0    = make_result(KIND_BAD_ESC, 8'h00);
						end else begin
							phase_d = PH_ESC;
						end
					end else begin
						res_cnt = end_of_string ? 2'd2 : 2'd1;
						res0    = (in_byte == cfg.separator_char) ?
						          make_result(KIND_FIELD, 8'h00) :
						          make_result(KIND_DATA, in_byte);
						res1    = make_result(KIND_LIST, 8'h00);
					end
				end
			endcase
		end

		// final byte: back to marker matching
		if (end_of_string) begin
			phase_d = PH_MARKER;
			pos_d   = 2'd0;
		end

		// mark the last result of this byte
		if (res_cnt == 2'd1)
			res0.run_last = 1'b1;
		if (res_cnt == 2'd2)
			res1.run_last = 1'b1;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MARKER;
			pos_q   <= 2'd0;
		end else if (step) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
		end
	end

	assign st.phase      = phase_q;
	assign st.marker_pos = pos_q;

endmodule

@@ hdl/efld_outq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efld_outq
// Small result queue: takes up to two results per cycle, hands out one word
// per cycle on the output stream while tready is high.
// ----------------------------------------------------------------------------
module efld_outq import efld_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_cnt,
	input  result_t    push0,
	input  result_t    push1,
	output logic       room,
	output logic       tvalid,
	input  logic       tready,
	output result_t    head,
	output logic [QCNT_W-1:0] count
);

	result_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_nx;
	logic [QCNT_W-1:0] cnt_q;
	logic              pop;

	assign pop       = tvalid && tready;
	assign tvalid    = (cnt_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign room      = (cnt_q <= QCNT_W'(QUEUE_DEPTH - 2));
	assign count     = cnt_q;
	assign wr_ptr_nx = wr_ptr_q + QPTR_W'(1);

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0)
			mem_q[wr_ptr_q] <= push0;
		if (push_cnt == 2'd2)
			mem_q[wr_ptr_nx] <= push1;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push_cnt);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			cnt_q <= cnt_q + QCNT_W'(push_cnt) - QCNT_W'(pop);
		end
	end

endmodule

@@ hdl/escaped_field_list_decoder_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_field_list_decoder_unit
// Path: an accepted byte waits in the input register; its results go to the queue.
// Throughput: one byte per cycle while the queue has room for two words; a final
//   byte that gives two results is absorbed by a four-word result queue.
// Reset: arst_n clears control state and loads the default configuration.
// ----------------------------------------------------------------------------
module escaped_field_list_decoder_unit import efld_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic        s_axis_tlast,   // end_of_string
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
	output logic [2:0]  m_axis_tuser,   // [2:0] kind
	output logic        m_axis_tlast,   // run_last
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);

	cfg_t              cfg_q;
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic              adv;
	logic              room;
	logic [1:0]        res_cnt, push_cnt;
	result_t           res0, res1, head;
	dec_state_t        st;
	logic [QCNT_W-1:0] q_count;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.marker_length  <= 2'd2;
			cfg_q.start_marker   <= 16'h4C5C;
			cfg_q.escape_char    <= 8'h5C;
			cfg_q.separator_char <= 8'h2C;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_MARKER_LEN: cfg_q.marker_length  <= cfg_wdata[1:0];
				REG_START_MARK: cfg_q.start_marker   <= cfg_wdata;
				REG_ESCAPE:     cfg_q.escape_char    <= cfg_wdata[7:0];
				REG_SEPARATOR:  cfg_q.separator_char <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// input register: moves on when the queue can take two words
	assign adv           = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	efld_decode u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (adv),
		.in_byte       (byte_s1),
		.end_of_string (last_s1),
		.cfg           (cfg_q),
		.res_cnt       (res_cnt),
		.res0          (res0),
		.res1          (res1),
		.st            (st)
	);

	assign push_cnt = adv ? res_cnt : 2'd0;

	efld_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (push_cnt),
		.push0    (res0),
		.push1    (res1),
		.room     (room),
		.tvalid   (m_axis_tvalid),
		.tready   (m_axis_tready),
		.head     (head),
		.count    (q_count)
	);

	assign m_axis_tdata = head.out_byte;
	assign m_axis_tuser = head.kind;
	assign m_axis_tlast = head.run_last;

	// checks
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QCNT_W'(QUEUE_DEPTH))
		else $error("result queue overfilled");

	a_final_resets: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> st.phase == PH_MARKER && st.marker_pos == 2'd0)
		else $error("final byte did not return decoder to marker matching");

	a_end_kinds_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == KIND_LIST || m_axis_tuser == KIND_BAD_MARK ||
		m_axis_tuser == KIND_BAD_ESC) |-> m_axis_tlast)
		else $error("list end or error word without run_last");

	a_drop_silent: assert property (@(posedge clk) disable iff (!arst_n)
		adv && st.phase == PH_DROP |-> res_cnt == 2'd0)
		else $error("dropped byte produced a result");

endmodule

@@ tb/efld_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efld_result_checker
// Watches the byte, result and configuration ports of the escaped field list
// decoder. It keeps its own copy of the decoder state and registers, works
// out the result words of every accepted byte and compares each accepted
// result word, field by field, with the oldest one still waiting.
// ----------------------------------------------------------------------------
module efld_result_checker import efld_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        s_axis_tlast,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [7:0]  m_axis_tdata,
	input  logic [2:0]  m_axis_tuser,
	input  logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata,
	output int          fail_count,
	output int          pending
);

	cfg_t       cfg;
	phase_t     dec_phase;
	logic [1:0] mark_pos;
	result_t    expected_words[$];
	int         errors = 0;

	function automatic result_t word_of(kind_t k, logic [7:0] b);
		result_t w;
		w.kind     = k;
		w.out_byte = (k == KIND_DATA) ? b : 8'h00;
		w.run_last = 1'b0;
		return w;
	endfunction

	// decode one raw byte and queue the result words it gives
	task automatic decode_byte(input logic [7:0] b, input logic last);
		result_t    res[2];
		int         n;
		int         len;
		logic [7:0] want;
		logic       handled;
		n       = 0;
		handled = 1'b0;
		len     = (cfg.marker_length > MAX_MARKER_LEN) ? MAX_MARKER_LEN : cfg.marker_length;

		// marker matching
		if (dec_phase == PH_MARKER) begin
			if (mark_pos < len) begin
				handled = 1'b1;
				want    = cfg.start_marker[8*mark_pos +: 8];
				if (b != want) begin
					res[n] = word_of(KIND_BAD_MARK, 8'h00);
					n++;
					dec_phase = PH_DROP;
				end else begin
					mark_pos = mark_pos + 2'd1;
					if (mark_pos >= len) begin
						dec_phase = PH_BODY;
						if (last) begin
							res[n] = word_of(KIND_LIST, 8'h00);
							n++;
						end
					end else if (last) begin
						// string ended inside the marker
						res[n] = word_of(KIND_BAD_MARK, 8'h00);
						n++;
					end
				end
			end else begin
				dec_phase = PH_BODY;
			end
		end

		if (!handled) begin
			case (dec_phase)
				PH_ESC: begin
					if (b == cfg.escape_char || b == cfg.separator_char) begin
						res[n] = word_of(KIND_DATA, b);
						n++;
						dec_phase = PH_BODY;
						if (last) begin
							res[n] = word_of(KIND_LIST, 8'h00);
							n++;
						end
					end else begin
						res[n] = word_of(KIND_BAD_ESC, 8'h00);
						n++;
						dec_phase = PH_DROP;
					end
				end
				PH_BODY: begin
					// escape wins when escape and separator are the same byte
					if (b == cfg.escape_char) begin
						if (last) begin
							res[n] = word_of(KIND_BAD_ESC, 8'h00);
							n++;
						end else begin
							dec_phase = PH_ESC;
						end
					end else begin
						res[n] = (b == cfg.separator_char) ? word_of(KIND_FIELD, 8'h00)
						                                   : word_of(KIND_DATA, b);
						n++;
						if (last) begin
							res[n] = word_of(KIND_LIST, 8'h00);
							n++;
						end
					end
				end
				default: ;  // dropping: nothing until the final byte
			endcase
		end

		if (n > 0)
			res[n-1].run_last = 1'b1;
		if (last) begin
			dec_phase = PH_MARKER;
			mark_pos  = 2'd0;
		end
		for (int i = 0; i < n; i++)
			expected_words.insert(expected_words.size(), res[i]);
	endtask

	// compare result words, follow register writes, predict accepted bytes
	always @(posedge clk or negedge arst_n) begin : watch
		result_t exp_w;
		if (!arst_n) begin
			cfg.marker_length  = 2'd2;
			cfg.start_marker   = 16'h4C5C;
			cfg.escape_char    = 8'h5C;
			cfg.separator_char = 8'h2C;
			dec_phase          = PH_MARKER;
			mark_pos           = 2'd0;
			expected_words.delete();
			pending    <= 0;
			fail_count <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_words.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("[%0t] unexpected word: kind %0d byte %02h last %0b",
							$realtime, m_axis_tuser, m_axis_tdata, m_axis_tlast);
				end else begin
					exp_w = expected_words[0];
					expected_words.delete(0);
					if (m_axis_tuser != exp_w.kind || m_axis_tdata != exp_w.out_byte ||
					    m_axis_tlast != exp_w.run_last) begin
						errors++;
						if (errors <= 10)
							$display("[%0t] mismatch: exp %0d/%02h/%0b got %0d/%02h/%0b",
								$realtime, exp_w.kind, exp_w.out_byte, exp_w.run_last,
								m_axis_tuser, m_axis_tdata, m_axis_tlast);
					end
				end
			end
			if (cfg_we) begin
				case (reg_idx_t'(cfg_addr))
					REG_MARKER_LEN: cfg.marker_length  = cfg_wdata[1:0];
					REG_START_MARK: cfg.start_marker   = cfg_wdata;
					REG_ESCAPE:     cfg.escape_char    = cfg_wdata[7:0];
					REG_SEPARATOR:  cfg.separator_char = cfg_wdata[7:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				decode_byte(s_axis_tdata, s_axis_tlast);
			pending    <= expected_words.size();
			fail_count <= errors;
		end
	end

endmodule

@@ tb/escaped_field_list_decoder_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escaped_field_list_decoder_unit_tb
// Drives coded strings into the decoder under several register settings:
// a directed set of marker, escape and separator cases, then mostly
// well-formed random strings mixed with broken ones and noise. Both stream
// sides idle at random; one stretch backs up the result side. The checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module escaped_field_list_decoder_unit_tb;
	import efld_pkg::*;

	localparam logic [7:0] DEF_ESC  = 8'h5C;  // '\'
	localparam logic [7:0] DEF_MK2  = 8'h4C;  // 'L'
	localparam logic [7:0] DEF_SEP  = 8'h2C;  // ','
	localparam int         HOLD_CYC = 80;
	localparam int         PHASE_BYTES = 55;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;    // [7:0] in_byte
	logic        s_axis_tlast;    // end_of_string
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;    // [7:0] out_byte
	logic [2:0]  m_axis_tuser;    // [2:0] kind
	logic        m_axis_tlast;    // run_last
	logic        cfg_we;
	logic [1:0]  cfg_addr;
	logic [15:0] cfg_wdata;
	int          fail_count;
	int          pending;

	// register values as last written, used to shape strings
	logic [1:0]  tb_len  = 2'd2;
	logic [15:0] tb_mark = 16'h4C5C;
	logic [7:0]  tb_esc  = DEF_ESC;
	logic [7:0]  tb_sep  = DEF_SEP;

	bit tx_no_idle  = 1'b0;
	bit rx_no_idle  = 1'b0;
	bit rx_hold_req = 1'b0;
	int bytes_sent  = 0;

	escaped_field_list_decoder_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	efld_result_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// run limit
	initial begin
		#2ms;
		$display("end of test: mismatches");
		$finish;
	end

	// result side: random stall per word, plus one long hold on request
	initial begin : rx_side
		int stall;
		m_axis_tready = 1'b0;
		wait (arst_n);
		forever begin
			stall = rx_no_idle ? 0 : $urandom_range(0, 17);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				stall = HOLD_CYC;
			end
			if (stall > 0) begin
				@(negedge clk) m_axis_tready = 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk) m_axis_tready = 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// offer one word and wait for its handshake
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = tx_no_idle ? 0 : $urandom_range(0, 17);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = b;
		s_axis_tlast  = last;
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
	endtask

	// stop offering, let every expected word arrive, then let the block settle
	task automatic wait_idle();
		@(negedge clk) s_axis_tvalid = 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_addr  = idx;
		cfg_wdata = val;
		@(negedge clk) cfg_we = 1'b0;
		case (idx)
			REG_MARKER_LEN: tb_len  = val[1:0];
			REG_START_MARK: tb_mark = val;
			REG_ESCAPE:     tb_esc  = val[7:0];
			REG_SEPARATOR:  tb_sep  = val[7:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [1:0] len, input logic [15:0] mark,
	                          input logic [7:0] esc, input logic [7:0] sep);
		write_reg(REG_MARKER_LEN, {14'd0, len});
		write_reg(REG_START_MARK, mark);
		write_reg(REG_ESCAPE, {8'd0, esc});
		write_reg(REG_SEPARATOR, {8'd0, sep});
	endtask

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == tb_esc || b == tb_sep);
		return b;
	endfunction

	// one random string: mostly well-formed, some broken, some noise
	task automatic send_string();
		logic [7:0] str_q[$];
		int shape;
		int mlen;
		int ntok;
		shape = $urandom_range(0, 9);
		mlen  = (tb_len > 2) ? 2 : tb_len;
		if (shape <= 7) begin
			for (int i = 0; i < mlen; i++)
				str_q.insert(str_q.size(), tb_mark[8*i +: 8]);
			ntok = $urandom_range(0, 8);
			if (mlen == 0 && ntok == 0)
				ntok = 1;
			for (int i = 0; i < ntok; i++) begin
				case ($urandom_range(0, 5))
					0: str_q.insert(str_q.size(), tb_sep);
					1: begin
						str_q.insert(str_q.size(), tb_esc);
						str_q.insert(str_q.size(), tb_esc);
					end
					2: begin
						str_q.insert(str_q.size(), tb_esc);
						str_q.insert(str_q.size(), tb_sep);
					end
					default: str_q.insert(str_q.size(), plain_byte());
				endcase
			end
			// trailing escape, or a bad escape followed by dropped bytes
			if (shape == 6) begin
				str_q.insert(str_q.size(), tb_esc);
			end else if (shape == 7) begin
				str_q.insert(str_q.size(), tb_esc);
				str_q.insert(str_q.size(), plain_byte());
				repeat ($urandom_range(0, 3))
					str_q.insert(str_q.size(), 8'($urandom_range(0, 255)));
			end
		end else if (shape == 8) begin
			// short string or a broken marker
			if (mlen == 2 && $urandom_range(0, 1))
				str_q.insert(str_q.size(), tb_mark[7:0]);
			else
				repeat ($urandom_range(1, 4))
					str_q.insert(str_q.size(), 8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(1, 6)) begin
				case ($urandom_range(0, 3))
					0: str_q.insert(str_q.size(), tb_esc);
					1: str_q.insert(str_q.size(), tb_sep);
					2: str_q.insert(str_q.size(), tb_mark[8*$urandom_range(0, 1) +: 8]);
					default: str_q.insert(str_q.size(), 8'($urandom_range(0, 255)));
				endcase
			end
		end
		for (int i = 0; i < str_q.size(); i++)
			send_byte(str_q[i], i == str_q.size() - 1);
	endtask

	initial begin : stimulus
		int target;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'h00;
		s_axis_tlast  = 1'b0;
		cfg_we        = 1'b0;
		cfg_addr      = REG_MARKER_LEN;
		cfg_wdata     = 16'h0000;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed, reset configuration: marker is '\' 'L'
		// exactly the marker
		send_byte(DEF_ESC, 1'b0);
		send_byte(DEF_MK2, 1'b1);
		// string ends inside the marker
		send_byte(DEF_ESC, 1'b1);
		// wrong marker, then a dropped tail
		send_byte(8'h58, 1'b0);
		send_byte(8'h62, 1'b1);
		// extreme bytes, separator, both escaped specials
		send_byte(DEF_ESC, 1'b0);
		send_byte(DEF_MK2, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(DEF_SEP, 1'b0);
		send_byte(DEF_ESC, 1'b0);
		send_byte(DEF_ESC, 1'b0);
		send_byte(DEF_ESC, 1'b0);
		send_byte(DEF_SEP, 1'b0);
		send_byte(8'hFF, 1'b1);
		// bad escape as the final byte
		send_byte(DEF_ESC, 1'b0);
		send_byte(DEF_MK2, 1'b0);
		send_byte(DEF_ESC, 1'b0);
		send_byte(8'h71, 1'b1);
		// separator as the final byte
		send_byte(DEF_ESC, 1'b0);
		send_byte(DEF_MK2, 1'b0);
		send_byte(DEF_SEP, 1'b1);
		// trailing escape
		send_byte(DEF_ESC, 1'b0);
		send_byte(DEF_MK2, 1'b0);
		send_byte(DEF_ESC, 1'b1);
		wait_idle();

		// random strings under a series of register settings
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: set_config(2'd0, 16'h0000, 8'h00, 8'hFF);
				1: set_config(2'd3, 16'hFFFF, 8'hFF, 8'h00);
				2: begin
					tb_esc = 8'($urandom_range(0, 255));
					set_config(2'd1, 16'($urandom_range(0, 65535)), tb_esc, tb_esc);
				end
				3: set_config(2'd2, 16'($urandom_range(0, 65535)),
				              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				4: set_config(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
				              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				default: set_config(2'd2, 16'h4C5C, DEF_ESC, DEF_SEP);
			endcase

			// back up the result side while bytes keep coming
			if (p == 3) begin
				tx_no_idle  = 1'b1;
				rx_hold_req = 1'b1;
				target = bytes_sent + 40;
				while (bytes_sent < target)
					send_string();
				wait_idle();
			end

			target = bytes_sent + PHASE_BYTES;
			while (bytes_sent < target) begin
				tx_no_idle = ($urandom_range(0, 3) == 0);
				rx_no_idle = ($urandom_range(0, 3) == 0);
				send_string();
			end
			wait_idle();
		end

		// drain
		for (int i = 0; i < 4000 && pending != 0; i++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (pending != 0)
			$display("%0d expected words never arrived", pending);
		if (fail_count == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ escaped_field_list_decoder_unit.f @@
hdl/efld_pkg.sv
hdl/efld_decode.sv
hdl/efld_outq.sv
hdl/escaped_field_list_decoder_unit.sv
tb/efld_result_checker.sv
tb/escaped_field_list_decoder_unit_tb.sv
